### sv/lcgud_pkg.sv
// Shared widths, codes and reset values of the LCG uniform draw unit.
`default_nettype none

package lcgud_pkg;

  localparam int DATA_W    = 32;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int CFG_IDX_W = 2;
  localparam int DIV_CNT_W = $clog2(PROD_W);

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MULTIPLIER = 2'd0,
    REG_INCREMENT  = 2'd1,
    REG_MODULUS    = 2'd2,
    REG_SEED       = 2'd3
  } cfg_reg_t;

  // transaction kinds
  localparam logic MODE_DRAW   = 1'b0;
  localparam logic MODE_RESEED = 1'b1;

  localparam logic [DATA_W-1:0] MULTIPLIER_RST = 32'd48271;
  localparam logic [DATA_W-1:0] INCREMENT_RST  = 32'd0;
  localparam logic [DATA_W-1:0] MODULUS_RST    = 32'd2147483647;
  localparam logic [DATA_W-1:0] SEED_RST       = 32'd1;

  // divider request from the sequencer
  typedef struct packed {
    logic              start;
    logic [PROD_W-1:0] dividend;
    logic [DATA_W-1:0] divisor;
  } div_req_t;

endpackage : lcgud_pkg

`default_nettype wire

### sv/lcgud_if.sv
// Valid/ready channel interfaces for draw requests and draw results.
`default_nettype none

interface lcgud_in_if
  import lcgud_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic                     mode;
  logic signed [DATA_W-1:0] bound_a;
  logic signed [DATA_W-1:0] bound_b;

  modport source (output valid, output mode, output bound_a, output bound_b, input ready);
  modport sink   (input valid, input mode, input bound_a, input bound_b, output ready);
endinterface : lcgud_in_if

interface lcgud_out_if
  import lcgud_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] uniform_value;
  logic        [DATA_W-1:0] raw_state;

  modport source (output valid, output uniform_value, output raw_state, input ready);
  modport sink   (input valid, input uniform_value, input raw_state, output ready);
endinterface : lcgud_out_if

`default_nettype wire

### sv/lcgud_mul.sv
// Shared 32x32 multiplier with a registered 64-bit product.
`default_nettype none

module lcgud_mul
  import lcgud_pkg::*;
(
  input  wire logic              clk,
  input  wire logic [DATA_W-1:0] a,
  input  wire logic [DATA_W-1:0] b,
  output logic      [PROD_W-1:0] p
);

  always_ff @(posedge clk) begin
    p <= PROD_W'(a) * PROD_W'(b);
  end

endmodule : lcgud_mul

`default_nettype wire

### sv/lcgud_div.sv
// Restoring 64/32 divider, one quotient bit per cycle.
`default_nettype none

module lcgud_div
  import lcgud_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire div_req_t          req,
  output logic                   done,
  output logic      [PROD_W-1:0] quo,
  output logic      [DATA_W-1:0] rem
);

  logic [DATA_W-1:0]    dvs;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic [DATA_W:0]      rem_shift;
  logic [DATA_W:0]      diff;
  logic                 ge;

  assign rem_shift = {rem, quo[PROD_W-1]};
  assign diff      = rem_shift - {1'b0, dvs};
  assign ge        = ~diff[DATA_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(PROD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath, no reset
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      quo <= req.dividend;
      dvs <= req.divisor;
    end else if (busy) begin
      rem <= ge ? diff[DATA_W-1:0] : rem_shift[DATA_W-1:0];
      quo <= {quo[PROD_W-2:0], ge};
    end
  end

endmodule : lcgud_div

`default_nettype wire

### sv/lcg_uniform_draw_unit.sv
// Top level of the LCG uniform draw unit: sequencer, registers and output stage.
`default_nettype none

// Linear congruential generator x' = (multiplier*x + increment) mod modulus
// (modulus 0 = wrap at 2^32) that returns draws scaled into a signed 32-bit integer range.
// A draw transaction orders its bounds, returns lo + (hi-lo)*(x-xmin)/(xmax-xmin)
// (saturated at hi, lo when the span is empty) with the state used, then steps.
// A reseed transaction loads seed_value mod modulus, steps once and returns
// nothing. One transaction at a time: ready is low from acceptance until the
// step has finished. All reductions and the range scaling go through one
// shared radix-2 divider and one registered multiplier. With modulus 0 the
// reductions skip the divider, and with an empty generator span so does the
// scaling. A finished draw waits until the output register is free; the
// step only proceeds once that register has taken it.
// Configuration may be written only while ready is high and no step is due.

module lcg_uniform_draw_unit
  import lcgud_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  lcgud_in_if.sink                  draw_in,
  lcgud_out_if.source               draw_out,
  input  wire logic                 cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [DATA_W-1:0]    cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SEED_WAIT,
    S_DRAW_MUL,
    S_DRAW_PROD,
    S_DRAW_WAIT,
    S_EMIT,
    S_STEP_MUL,
    S_STEP_PROD,
    S_STEP_ADD,
    S_STEP_WAIT
  } state_t;

  state_t state;

  // configuration
  logic [DATA_W-1:0] multiplier;
  logic [DATA_W-1:0] increment;
  logic [DATA_W-1:0] modulus;
  logic [DATA_W-1:0] seed_value;

  // generator state and per-draw working registers
  logic [DATA_W-1:0] gen_state;
  logic [DATA_W-1:0] lo;
  logic [DATA_W-1:0] span;
  logic [DATA_W-1:0] q;
  logic [PROD_W-1:0] step_sum;

  // output register
  logic              out_valid;
  logic [DATA_W-1:0] out_value;
  logic [DATA_W-1:0] out_raw;

  // shared units
  logic [DATA_W-1:0] mul_a;
  logic [DATA_W-1:0] mul_b;
  logic [PROD_W-1:0] mul_p;
  div_req_t          div_req;
  logic              div_done;
  logic [PROD_W-1:0] div_quo;
  logic [DATA_W-1:0] div_rem;

  logic              accept;
  logic              a_le_b;
  logic [DATA_W-1:0] xmin;
  logic [DATA_W-1:0] num;
  logic [DATA_W-1:0] den;
  logic              emit_go;

  assign draw_in.ready = (state == S_IDLE);
  assign accept        = draw_in.valid && draw_in.ready;
  assign a_le_b        = draw_in.bound_a <= draw_in.bound_b;

  // span of the generator: xmin is 1 for a multiplicative generator
  assign xmin = (increment == '0) ? DATA_W'(1) : '0;
  assign num  = gen_state - xmin;
  assign den  = modulus - DATA_W'(1) - xmin;

  assign emit_go = (state == S_EMIT) && (!out_valid || draw_out.ready);

  assign draw_out.valid         = out_valid;
  assign draw_out.uniform_value = out_value;
  assign draw_out.raw_state     = out_raw;

  // multiplier operands: scaling product during a draw, LCG product otherwise
  always_comb begin
    if (state == S_DRAW_MUL) begin
      mul_a = span;
      mul_b = num;
    end else begin
      mul_a = multiplier;
      mul_b = gen_state;
    end
  end

  // divider requests
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = step_sum;
    div_req.divisor  = modulus;
    case (state)
      S_IDLE: begin
        div_req.start    = accept && (draw_in.mode == MODE_RESEED) && (modulus != '0);
        div_req.dividend = {{DATA_W{1'b0}}, seed_value};
      end
      S_DRAW_PROD: begin
        div_req.start    = (den != '0);
        div_req.dividend = mul_p;
        div_req.divisor  = den;
      end
      S_STEP_ADD: begin
        div_req.start = (modulus != '0);
      end
      default: begin
        div_req.start = 1'b0;
      end
    endcase
  end

  lcgud_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  lcgud_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .done (div_done),
    .quo  (div_quo),
    .rem  (div_rem)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      multiplier <= MULTIPLIER_RST;
      increment  <= INCREMENT_RST;
      modulus    <= MODULUS_RST;
      seed_value <= SEED_RST;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_MULTIPLIER: multiplier <= cfg_data;
        REG_INCREMENT:  increment  <= cfg_data;
        REG_MODULUS:    modulus    <= cfg_data;
        REG_SEED:       seed_value <= cfg_data;
        default:        ;
      endcase
    end
  end

  // sequencer, generator state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      gen_state <= '0;
      out_valid <= 1'b0;
    end else begin
      if (emit_go) begin
        out_valid <= 1'b1;
      end else if (out_valid && draw_out.ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            if (draw_in.mode == MODE_RESEED) begin
              if (modulus == '0) begin
                gen_state <= seed_value;
                state     <= S_STEP_MUL;
              end else begin
                state <= S_SEED_WAIT;
              end
            end else begin
              state <= S_DRAW_MUL;
            end
          end
        end
        S_SEED_WAIT: begin
          if (div_done) begin
            gen_state <= div_rem;
            state     <= S_STEP_MUL;
          end
        end
        S_DRAW_MUL: state <= S_DRAW_PROD;
        S_DRAW_PROD: begin
          state <= (den == '0) ? S_EMIT : S_DRAW_WAIT;
        end
        S_DRAW_WAIT: begin
          if (div_done) state <= S_EMIT;
        end
        S_EMIT: begin
          if (emit_go) state <= S_STEP_MUL;
        end
        S_STEP_MUL:  state <= S_STEP_PROD;
        S_STEP_PROD: state <= S_STEP_ADD;
        S_STEP_ADD: begin
          if (modulus == '0) begin
            gen_state <= step_sum[DATA_W-1:0];
            state     <= S_IDLE;
          end else begin
            state <= S_STEP_WAIT;
          end
        end
        S_STEP_WAIT: begin
          if (div_done) begin
            gen_state <= div_rem;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      lo   <= a_le_b ? draw_in.bound_a : draw_in.bound_b;
      span <= a_le_b ? (draw_in.bound_b - draw_in.bound_a)
                     : (draw_in.bound_a - draw_in.bound_b);
    end
    if (state == S_DRAW_PROD && den == '0) begin
      q <= '0;
    end else if (state == S_DRAW_WAIT && div_done) begin
      // state beyond the span saturates at hi
      q <= (div_quo > {{DATA_W{1'b0}}, span}) ? span : div_quo[DATA_W-1:0];
    end
    if (state == S_STEP_PROD) begin
      step_sum <= mul_p + {{DATA_W{1'b0}}, increment};
    end
    if (emit_go) begin
      out_value <= lo + q;
      out_raw   <= gen_state;
    end
  end

endmodule : lcg_uniform_draw_unit

`default_nettype wire

### sv/lcgud_checker.sv
// Port-level checks on the LCG uniform draw unit, bound to the top level.
`default_nettype none

module lcgud_checker
  import lcgud_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [DATA_W-1:0] out_value,
  input wire logic [DATA_W-1:0] out_raw
);

  // a result offered but not taken stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn before it was taken");

  // and keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_value) && $stable(out_raw))
    else $error("stalled result changed");

  // one transaction at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second transaction taken while busy");

  // no result appears right after acceptance
  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !$rose(out_valid) ##1 !$rose(out_valid))
    else $error("result appeared too soon after acceptance");

endmodule : lcgud_checker

bind lcg_uniform_draw_unit lcgud_checker u_lcgud_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (draw_in.valid),
  .in_ready  (draw_in.ready),
  .out_valid (draw_out.valid),
  .out_ready (draw_out.ready),
  .out_value (draw_out.uniform_value),
  .out_raw   (draw_out.raw_state)
);

`default_nettype wire
